/* design/mas_pkg.sv */
package mas_pkg;

	localparam int SAMPLE_W    = 12;
	localparam int SUM_W       = 16;
	localparam int AVG_SHIFT   = 4;
	localparam int MOIST_W     = 15;
	localparam int PROD_W      = SAMPLE_W + MOIST_W;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 15;
	localparam int QUEUE_DEPTH = 2;

	localparam int BURST_LEN_DEFAULT = 16;

	localparam logic [MOIST_W-1:0]  FULL_SCALE   = 15'd25600;
	localparam logic [SAMPLE_W-1:0] DRY_RESET    = 12'd3000;
	localparam logic [SAMPLE_W-1:0] WET_RESET    = 12'd1500;
	localparam logic [MOIST_W-1:0]  THRESH_RESET = 15'd7680;

	localparam logic [CFG_IDX_W-1:0] REG_DRY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WET    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd2;

	typedef struct packed {
		logic                fault;
		logic [SAMPLE_W-1:0] avg;
	} job_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] dry_point;
		logic [SAMPLE_W-1:0] wet_point;
		logic [MOIST_W-1:0]  water_threshold;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] avg_raw;
		logic [MOIST_W-1:0]  moisture;
		logic                water_low;
		logic                fault;
	} reading_t;

endpackage

/* design/mas_if.sv */
interface mas_sample_if;
	logic                          valid;
	logic                          ready;
	logic [mas_pkg::SAMPLE_W-1:0]  sample;
	logic                          sample_ok;

	modport source(output valid, sample, sample_ok, input ready);
	modport sink(input valid, sample, sample_ok, output ready);
endinterface

interface mas_reading_if;
	logic                          valid;
	logic                          ready;
	logic [mas_pkg::SAMPLE_W-1:0]  avg_raw;
	logic [mas_pkg::MOIST_W-1:0]   moisture;
	logic                          water_low;
	logic                          fault;

	modport source(output valid, avg_raw, moisture, water_low, fault, input ready);
	modport sink(input valid, avg_raw, moisture, water_low, fault, output ready);
endinterface

/* design/mas_front.sv */
module mas_front #(
	parameter int BURST_LEN = mas_pkg::BURST_LEN_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [mas_pkg::SAMPLE_W-1:0] sample,
	input  logic                         sample_ok,
	output logic                         push,
	output mas_pkg::job_t                push_job
);

	localparam int CNT_W = (BURST_LEN > 2) ? $clog2(BURST_LEN) : 1;
	localparam logic [CNT_W-1:0] LAST = CNT_W'(BURST_LEN - 1);

	logic [mas_pkg::SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [mas_pkg::SUM_W-1:0] sum_next;

	assign sum_next = sum_q + mas_pkg::SUM_W'(sample);

	always_comb begin
		push              = accept && (!sample_ok || cnt_q == LAST);
		push_job.fault    = !sample_ok;
		push_job.avg      = sample_ok ?
			sum_next[mas_pkg::AVG_SHIFT +: mas_pkg::SAMPLE_W] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (!sample_ok || cnt_q == LAST) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_next;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

/* design/mas_queue.sv */
module mas_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mas_pkg::job_t push_job,
	input  logic          pop,
	output logic          full,
	output logic          nonempty,
	output mas_pkg::job_t head
);

	localparam int PTR_W = (mas_pkg::QUEUE_DEPTH > 2) ? $clog2(mas_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(mas_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(mas_pkg::QUEUE_DEPTH - 1);

	mas_pkg::job_t    slot_q [mas_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = cnt_q == CNT_W'(mas_pkg::QUEUE_DEPTH);
	assign nonempty = cnt_q != '0;
	assign head     = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) slot_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			if (pop && nonempty) rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			unique case ({push && !full, pop && nonempty})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* design/mas_back.sv */
module mas_back (
	input  logic              clk,
	input  logic              arst_n,
	input  mas_pkg::cfg_t     cfg,
	input  logic              job_valid,
	input  mas_pkg::job_t     job,
	output logic              pop,
	output logic              rd_valid,
	input  logic              rd_ready,
	output mas_pkg::reading_t rd
);

	localparam int SW = mas_pkg::SAMPLE_W;
	localparam int MW = mas_pkg::MOIST_W;
	// dividend padded to an even bit count, two quotient bits per cycle
	localparam int NUM_W  = mas_pkg::PROD_W + (mas_pkg::PROD_W % 2);
	localparam int STEPS  = NUM_W / 2;
	localparam int STEP_W = $clog2(STEPS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic [NUM_W-1:0]  num_q;
	logic [SW:0]       rem_q;
	logic [SW-1:0]     den_q;
	logic [SW-1:0]     avg_q;

	logic              res_valid_q;
	mas_pkg::reading_t res_q;

	logic [SW-1:0]                 hi, lo, diff;
	logic [mas_pkg::PROD_W-1:0]    prod;
	logic                          special;
	logic [MW-1:0]                 special_moist;
	logic                          load_ok;
	logic [NUM_W-1:0]              num_next;
	logic [SW:0]                   rem_next;

	assign hi   = (cfg.dry_point >= cfg.wet_point) ? cfg.dry_point : cfg.wet_point;
	assign lo   = (cfg.dry_point >= cfg.wet_point) ? cfg.wet_point : cfg.dry_point;
	assign diff = hi - job.avg;
	assign prod = mas_pkg::PROD_W'(diff) * mas_pkg::PROD_W'(mas_pkg::FULL_SCALE);

	assign special = job.fault || hi == lo || job.avg >= hi || job.avg <= lo;

	always_comb begin
		priority if (job.fault || hi == lo || job.avg >= hi) special_moist = '0;
		else                                                  special_moist = mas_pkg::FULL_SCALE;
	end

	assign load_ok = !res_valid_q || rd_ready;
	assign pop     = state_q == ST_IDLE && job_valid && (!special || load_ok);

	// restoring division, two bits per cycle
	always_comb begin
		logic [NUM_W-1:0] n;
		logic [SW:0]      r;
		n = num_q;
		r = rem_q;
		for (int k = 0; k < 2; k++) begin
			r = {r[SW-1:0], n[NUM_W-1]};
			n = {n[NUM_W-2:0], 1'b0};
			if (r >= {1'b0, den_q}) begin
				r    = r - {1'b0, den_q};
				n[0] = 1'b1;
			end
		end
		num_next = n;
		rem_next = r;
	end

	always_ff @(posedge clk) begin
		if (pop && !special) begin
			num_q <= NUM_W'(prod);
			rem_q <= '0;
			den_q <= hi - lo;
			avg_q <= job.avg;
		end else if (state_q == ST_DIV) begin
			num_q <= num_next;
			rem_q <= rem_next;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && special) begin
			res_q.avg_raw   <= job.avg;
			res_q.moisture  <= special_moist;
			res_q.water_low <= !job.fault && special_moist < cfg.water_threshold;
			res_q.fault     <= job.fault;
		end else if (state_q == ST_FIN && load_ok) begin
			res_q.avg_raw   <= avg_q;
			res_q.moisture  <= num_q[MW-1:0];
			res_q.water_low <= num_q[MW-1:0] < cfg.water_threshold;
			res_q.fault     <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop && !special) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (load_ok) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if ((pop && special) || (state_q == ST_FIN && load_ok))
				res_valid_q <= 1'b1;
			else if (rd_ready)
				res_valid_q <= 1'b0;
		end
	end

	assign rd_valid = res_valid_q;
	assign rd       = res_q;

endmodule

/* design/moisture_average_and_scale.sv */
// Soil moisture burst averager.
// samples (sink): one 12-bit converter reading and its ok flag per beat.
// readings (source): avg_raw, moisture (percent, 8 fraction bits),
//   water_low and fault. One reading per BURST_LEN good samples, and one
//   fault reading for each failed sample, which also restarts the burst.
// cfg_we/cfg_index/cfg_data: 0 dry point, 1 wet point, 2 water threshold;
//   index 3 is ignored. Write only while the block is idle.
// Throughput: one sample beat per cycle. The back end takes one reading at
//   a time: a fault or clipped reading is loaded straight into the output
//   register; a scaled reading is multiplied as it leaves the queue, run
//   through a 2-bit-per-cycle divider, then loaded. A 2-entry queue between
//   the accumulator and the divider absorbs bursts; when it is full, samples.ready drops.
// From the burst-closing beat, a reading passes through the queue and the
//   output register, and a scaled one also through the divider states.
// When readings.ready is low the reading holds; the divider may finish the
//   next one and wait behind it, and the accumulator keeps taking samples
//   until the queue fills.
// Reset clears the burst, the queue and the output, and loads the
//   calibration registers with their defaults (3000, 1500, 7680).
module moisture_average_and_scale #(
	parameter int BURST_LEN = mas_pkg::BURST_LEN_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	mas_sample_if.sink                      samples,
	mas_reading_if.source                   readings,
	input  logic                            cfg_we,
	input  logic [mas_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mas_pkg::CFG_DATA_W-1:0]  cfg_data
);

	mas_pkg::cfg_t     cfg_q;
	mas_pkg::job_t     push_job, head;
	mas_pkg::reading_t rd;
	logic              push, pop, full, nonempty, accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dry_point       <= mas_pkg::DRY_RESET;
			cfg_q.wet_point       <= mas_pkg::WET_RESET;
			cfg_q.water_threshold <= mas_pkg::THRESH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mas_pkg::REG_DRY:    cfg_q.dry_point <= cfg_data[mas_pkg::SAMPLE_W-1:0];
				mas_pkg::REG_WET:    cfg_q.wet_point <= cfg_data[mas_pkg::SAMPLE_W-1:0];
				mas_pkg::REG_THRESH: cfg_q.water_threshold <= cfg_data[mas_pkg::MOIST_W-1:0];
				default:             cfg_q <= cfg_q;
			endcase
		end
	end

	assign samples.ready = !full;
	assign accept        = samples.valid && !full;

	mas_front #(.BURST_LEN(BURST_LEN)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.sample    (samples.sample),
		.sample_ok (samples.sample_ok),
		.push      (push),
		.push_job  (push_job)
	);

	mas_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (full),
		.nonempty (nonempty),
		.head     (head)
	);

	mas_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (nonempty),
		.job       (head),
		.pop       (pop),
		.rd_valid  (readings.valid),
		.rd_ready  (readings.ready),
		.rd        (rd)
	);

	assign readings.avg_raw   = rd.avg_raw;
	assign readings.moisture  = rd.moisture;
	assign readings.water_low = rd.water_low;
	assign readings.fault     = rd.fault;

endmodule

/* design/mas_checker.sv */
module mas_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rd_valid,
	input logic                          rd_ready,
	input logic [mas_pkg::SAMPLE_W-1:0]  avg_raw,
	input logic [mas_pkg::MOIST_W-1:0]   moisture,
	input logic                          water_low,
	input logic                          fault
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid && !rd_ready |=> rd_valid)
		else $error("reading dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid && !rd_ready |=> $stable({avg_raw, moisture, water_low, fault}))
		else $error("stalled reading changed");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid && fault |-> avg_raw == '0 && moisture == '0 && !water_low)
		else $error("fault beat carries data");

	a_scale: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid |-> moisture <= mas_pkg::FULL_SCALE)
		else $error("moisture above full scale");

endmodule

bind moisture_average_and_scale mas_checker u_mas_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rd_valid  (readings.valid),
	.rd_ready  (readings.ready),
	.avg_raw   (readings.avg_raw),
	.moisture  (readings.moisture),
	.water_low (readings.water_low),
	.fault     (readings.fault)
);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
	import mas_pkg::*;

	localparam int                   BURST       = BURST_LEN_DEFAULT;
	localparam int                   SETTLE_CYC  = 40;
	localparam int                   HOLD_CYC    = 400;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic                ok;
	} sample_item_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mas_sample_if  sample_ch ();
	mas_reading_if reading_ch ();

	moisture_average_and_scale i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (sample_ch),
		.readings  (reading_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	sample_item_t sample_feed[$];
	reading_t     pending_readings[$];

	// calibration and burst state as the block should hold it
	logic [SAMPLE_W-1:0] cal_dry, cal_wet;
	logic [MOIST_W-1:0]  cal_thresh;
	logic [SUM_W-1:0]    acc_sum;
	int                  acc_count;

	int  err_cnt = 0;
	int  fed;
	int  tx_idle_pct = 0;
	int  rx_idle_pct = 0;
	bit  tx_pause = 1'b0;
	bit  rx_hold_req = 1'b0;
	int  rx_hold_left = 0;
	bit  in_fire = 1'b0;

	reading_t     got_r;
	reading_t     exp_r;
	sample_item_t next_item;

	function automatic logic [MOIST_W-1:0] scale_moisture(logic [SAMPLE_W-1:0] avg);
		logic [SAMPLE_W-1:0] hi, lo;
		logic [31:0]         num;
		hi = (cal_dry >= cal_wet) ? cal_dry : cal_wet;
		lo = (cal_dry >= cal_wet) ? cal_wet : cal_dry;
		if (hi == lo || avg >= hi)
			return '0;
		if (avg <= lo)
			return FULL_SCALE;
		num = ({20'd0, hi} - {20'd0, avg}) * 32'd25600;
		num = num / ({20'd0, hi} - {20'd0, lo});
		return num[MOIST_W-1:0];
	endfunction

	task automatic take_sample(sample_item_t it);
		reading_t            r;
		logic [SAMPLE_W-1:0] avg;
		r = '0;
		if (!it.ok) begin
			acc_sum   = '0;
			acc_count = 0;
			r.fault   = 1'b1;
			pending_readings.push_back(r);
		end else begin
			acc_sum   = acc_sum + {4'd0, it.value};
			acc_count = acc_count + 1;
			if (acc_count == BURST) begin
				avg         = acc_sum[SUM_W-1:AVG_SHIFT];
				r.avg_raw   = avg;
				r.moisture  = scale_moisture(avg);
				r.water_low = (r.moisture < cal_thresh);
				acc_sum     = '0;
				acc_count   = 0;
				pending_readings.push_back(r);
			end
		end
	endtask

	// monitor: checks reading beats, predicts from sample beats, tracks config
	always @(posedge clk) begin
		in_fire = sample_ch.valid && sample_ch.ready;
		if (arst_n) begin
			if (reading_ch.valid && reading_ch.ready) begin
				got_r.avg_raw   = reading_ch.avg_raw;
				got_r.moisture  = reading_ch.moisture;
				got_r.water_low = reading_ch.water_low;
				got_r.fault     = reading_ch.fault;
				if (pending_readings.size() == 0) begin
					$error("unexpected reading: avg_raw %0d moisture %0d fault %0d",
						got_r.avg_raw, got_r.moisture, got_r.fault);
					err_cnt++;
				end else begin
					exp_r = pending_readings.pop_front();
					if (got_r.avg_raw !== exp_r.avg_raw) begin
						$error("avg_raw: expected %0d, got %0d", exp_r.avg_raw, got_r.avg_raw);
						err_cnt++;
					end
					if (got_r.moisture !== exp_r.moisture) begin
						$error("moisture: expected %0d, got %0d", exp_r.moisture, got_r.moisture);
						err_cnt++;
					end
					if (got_r.water_low !== exp_r.water_low) begin
						$error("water_low: expected %0d, got %0d",
							exp_r.water_low, got_r.water_low);
						err_cnt++;
					end
					if (got_r.fault !== exp_r.fault) begin
						$error("fault: expected %0d, got %0d", exp_r.fault, got_r.fault);
						err_cnt++;
					end
				end
			end
			if (in_fire) begin
				next_item.value = sample_ch.sample;
				next_item.ok    = sample_ch.sample_ok;
				take_sample(next_item);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_DRY:    cal_dry    = cfg_data[SAMPLE_W-1:0];
					REG_WET:    cal_wet    = cfg_data[SAMPLE_W-1:0];
					REG_THRESH: cal_thresh = cfg_data[MOIST_W-1:0];
					default:    ;
				endcase
			end
		end
	end

	// sample driver
	always @(negedge clk) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
		end else if (!sample_ch.valid || in_fire) begin
			if (sample_feed.size() != 0 && !tx_pause && $urandom_range(99) >= tx_idle_pct) begin
				next_item = sample_feed.pop_front();
				sample_ch.valid     <= 1'b1;
				sample_ch.sample    <= next_item.value;
				sample_ch.sample_ok <= next_item.ok;
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	// reading sink, with an optional long hold-off
	always @(negedge clk) begin
		if (rx_hold_req) begin
			rx_hold_req  = 1'b0;
			rx_hold_left = HOLD_CYC;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left = rx_hold_left - 1;
			reading_ch.ready <= 1'b0;
		end else begin
			reading_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic push_item(int value, bit ok);
		sample_item_t it;
		it.value = value[SAMPLE_W-1:0];
		it.ok    = ok;
		sample_feed.push_back(it);
		fed++;
	endtask

	task automatic queue_burst();
		int kind, level, fault_at, v;
		kind     = $urandom_range(9);
		fault_at = ($urandom_range(9) == 0) ? $urandom_range(BURST - 1) : -1;
		if (kind < 5)
			level = $urandom_range(4095);
		else
			level = $urandom_range(cal_dry, cal_wet);
		for (int i = 0; i < BURST; i++) begin
			if (kind >= 8) begin
				v = $urandom_range(4095);
			end else begin
				v = level + $urandom_range(40) - 20;
				if (v < 0) v = 0;
				if (v > 4095) v = 4095;
			end
			push_item(v, i != fault_at);
		end
	endtask

	task automatic fill_random(int n);
		int pick;
		fed = 0;
		while (fed < n) begin
			pick = $urandom_range(19);
			if (pick == 0) begin
				push_item($urandom_range(4095), 1'b0);
			end else if (pick == 1) begin
				// misaligns the following bursts
				repeat ($urandom_range(1, BURST - 1)) push_item($urandom_range(4095), 1'b1);
			end else begin
				queue_burst();
			end
		end
		// leave a partial burst open across the next register write
		repeat ($urandom_range(BURST - 1)) push_item($urandom_range(4095), 1'b1);
	endtask

	task automatic drain();
		while (sample_feed.size() != 0 || sample_ch.valid) @(posedge clk);
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = '0;
		cfg_data             = '0;
		sample_ch.valid      = 1'b0;
		sample_ch.sample     = '0;
		sample_ch.sample_ok  = 1'b0;
		reading_ch.ready     = 1'b0;
		cal_dry              = DRY_RESET;
		cal_wet              = WET_RESET;
		cal_thresh           = THRESH_RESET;
		acc_sum              = '0;
		acc_count            = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: full-scale burst above dry, fault at burst start, fault mid-burst
		tx_idle_pct = 31;
		rx_idle_pct = 50;
		repeat (BURST) push_item(4095, 1'b1);
		push_item(0, 1'b0);
		repeat (3) push_item(0, 1'b1);
		push_item(4095, 1'b0);
		drain();

		fill_random(230);
		drain();

		// widest span, zero threshold; data bits above the register width dropped
		write_reg(REG_DRY, 15'h7fff);
		write_reg(REG_WET, 0);
		write_reg(REG_THRESH, 0);
		fill_random(230);
		drain();

		// swapped points
		write_reg(REG_DRY, 0);
		write_reg(REG_WET, 4095);
		write_reg(REG_THRESH, 25600);
		fill_random(230);
		drain();

		// equal points, threshold above full scale, ignored index
		tx_idle_pct = 50;
		rx_idle_pct = 31;
		write_reg(REG_DRY, 2000);
		write_reg(REG_WET, 2000);
		write_reg(REG_THRESH, 15'h7fff);
		write_reg(REG_UNUSED, 15'h7fff);
		fill_random(230);
		drain();

		write_reg(REG_DRY, 1);
		write_reg(REG_WET, 0);
		write_reg(REG_THRESH, 25601);
		fill_random(230);
		while (sample_feed.size() > 100) @(posedge clk);
		tx_pause = 1'b1;
		while (pending_readings.size() != 0) @(posedge clk);
		tx_pause = 1'b0;
		drain();

		write_reg(REG_DRY, $urandom_range(4095));
		write_reg(REG_WET, $urandom_range(4095));
		write_reg(REG_THRESH, $urandom_range(32767));
		fill_random(230);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_reg(REG_DRY, $urandom_range(2048, 4095));
		write_reg(REG_WET, $urandom_range(2047));
		write_reg(REG_THRESH, $urandom_range(25600));
		fill_random(230);
		// stall the output long enough for the block to back up into its input
		rx_hold_req = 1'b1;
		drain();

		write_reg(REG_DRY, $urandom_range(4095));
		write_reg(REG_WET, $urandom_range(4095));
		write_reg(REG_THRESH, $urandom_range(32767));
		fill_random(230);
		drain();

		if (err_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
